[rtl/core/stq_pkg.sv]
// Shared widths, types and register indexes of the sphere-to-quad contact test.
package stq_pkg;

  localparam int CB = 20;          // coordinate width, signed Q10.10
  localparam int DW = CB + 1;      // coordinate difference width
  localparam int SW = 2 * CB + 3;  // signed dot product width
  localparam int UW = 2 * CB + 2;  // non-negative dot product width
  localparam int HW = UW / 2;      // half width for split multiplies
  localparam int FW = 2 * UW;      // full product width
  localparam int CW = 3 * CB;      // packed corner width
  localparam int RW = CB - 1;      // radius width
  localparam int IW = 3;           // register index width

  typedef logic signed [CB-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef coord_t [2:0] cvec_t;    // index 0 is x, 1 is y, 2 is z
  typedef diff_t  [2:0] dvec_t;

  typedef enum logic [IW-1:0] {
    REG_CORNER_ONE   = 3'd0,
    REG_CORNER_TWO   = 3'd1,
    REG_CORNER_THREE = 3'd2,
    REG_CORNER_FOUR  = 3'd3,
    REG_RADIUS       = 3'd4
  } reg_idx_t;

endpackage

[rtl/core/sphere_touches_quad_surface.sv]
// Top level: configuration registers, item pipeline and result strobe.
// Results pass through stq_front, the edge lanes and the touches register; out_valid is the last valid bit.
// Throughput: one transaction per cycle; busy is always low and nothing stalls,
// since the receiver cannot hold results off and every stage moves each cycle.
// Reset (synchronous, rst_n low) clears the corner and radius registers to zero
// and drops every valid bit in flight; payload stages are not reset.
module sphere_touches_quad_surface (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [stq_pkg::CB-1:0] in_center_x,
  input  logic signed [stq_pkg::CB-1:0] in_center_y,
  input  logic signed [stq_pkg::CB-1:0] in_center_z,
  input  logic signed [stq_pkg::CB-1:0] in_probe_x,
  input  logic signed [stq_pkg::CB-1:0] in_probe_y,
  input  logic signed [stq_pkg::CB-1:0] in_probe_z,
  output logic                   out_valid,
  output logic                   out_touches,
  input  logic                   cfg_we,
  input  logic [stq_pkg::IW-1:0] cfg_index,
  input  logic [stq_pkg::CW-1:0] cfg_data
);

  // Configuration registers. The user changes them only while no transaction is in flight; unenforced.
  stq_pkg::cvec_t [3:0]   corner_r;
  logic [stq_pkg::RW-1:0] radius_r;
  logic [stq_pkg::UW-1:0] r2_r;
  logic [2*stq_pkg::RW-1:0] radius_sq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_r <= '0;
      radius_r <= '0;
    end else if (cfg_we) begin
      case (stq_pkg::reg_idx_t'(cfg_index))
        stq_pkg::REG_CORNER_ONE:   corner_r[0] <= cfg_data;
        stq_pkg::REG_CORNER_TWO:   corner_r[1] <= cfg_data;
        stq_pkg::REG_CORNER_THREE: corner_r[2] <= cfg_data;
        stq_pkg::REG_CORNER_FOUR:  corner_r[3] <= cfg_data;
        stq_pkg::REG_RADIUS:       radius_r    <= cfg_data[stq_pkg::RW-1:0];
        default: ;
      endcase
    end
  end

  // The squared radius is recomputed every cycle; it is settled long before
  // the first transaction after a write reaches the lanes.
  assign radius_sq = radius_r * radius_r;

  always_ff @(posedge clk) begin
    r2_r <= stq_pkg::UW'(radius_sq);
  end

  assign busy = 1'b0;

  stq_pkg::cvec_t center, probe;
  assign center = {in_center_z, in_center_y, in_center_x};
  assign probe  = {in_probe_z, in_probe_y, in_probe_x};

  // Stage one: differences and the box test.
  stq_pkg::dvec_t [3:0] w_s1;
  stq_pkg::dvec_t [3:0] d_s1;
  logic                 inside_s1;

  stq_front u_front (
    .clk      (clk),
    .corner   (corner_r),
    .center   (center),
    .probe    (probe),
    .w_r      (w_s1),
    .d_r      (d_s1),
    .inside_r (inside_s1)
  );

  // Stages two to five: one lane per edge. The far-end offset of an edge is
  // the near-end offset of the next edge.
  logic [3:0] hit_s5;

  for (genvar k = 0; k < 4; k++) begin : g_edge
    stq_edge u_edge (
      .clk   (clk),
      .w_s   (w_s1[k]),
      .w_e   (w_s1[(k+1)%4]),
      .d     (d_s1[k]),
      .r2    (r2_r),
      .hit_r (hit_s5[k])
    );
  end

  // The box flag rides alongside the lanes for four stages.
  logic [3:0] inside_r;

  always_ff @(posedge clk) begin
    inside_r <= {inside_r[2:0], inside_s1};
  end

  // Valid bits travel with the data; a set bit in the last place is the strobe.
  logic [5:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], start & ~busy};
    end
  end

  logic touches_r;

  always_ff @(posedge clk) begin
    touches_r <= (|hit_s5) | inside_r[3];
  end

  assign out_valid   = vld_r[5];
  assign out_touches = touches_r;

endmodule

[rtl/core/stq_front.sv]
// First pipeline stage: edge vectors, center offsets and the probe box test.
module stq_front (
  input  logic                    clk,
  input  stq_pkg::cvec_t [3:0]    corner,
  input  stq_pkg::cvec_t          center,
  input  stq_pkg::cvec_t          probe,
  output stq_pkg::dvec_t [3:0]    w_r,
  output stq_pkg::dvec_t [3:0]    d_r,
  output logic                    inside_r
);

  stq_pkg::dvec_t [3:0] w_nxt;
  stq_pkg::dvec_t [3:0] d_nxt;
  logic [2:0]           axis_in;
  logic                 inside_nxt;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int a = 0; a < 3; a++) begin
        w_nxt[k][a] = {center[a][stq_pkg::CB-1], center[a]}
                    - {corner[k][a][stq_pkg::CB-1], corner[k][a]};
        d_nxt[k][a] = {corner[(k+1)%4][a][stq_pkg::CB-1], corner[(k+1)%4][a]}
                    - {corner[k][a][stq_pkg::CB-1], corner[k][a]};
      end
    end
  end

  // The probe is inside when it is not below every corner nor above every one.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      axis_in[a] = ((probe[a] >= corner[0][a]) || (probe[a] >= corner[1][a]) ||
                    (probe[a] >= corner[2][a]) || (probe[a] >= corner[3][a])) &&
                   ((probe[a] <= corner[0][a]) || (probe[a] <= corner[1][a]) ||
                    (probe[a] <= corner[2][a]) || (probe[a] <= corner[3][a]));
    end
    inside_nxt = &axis_in;
  end

  always_ff @(posedge clk) begin
    w_r      <= w_nxt;
    d_r      <= d_nxt;
    inside_r <= inside_nxt;
  end

endmodule

[rtl/core/stq_edge.sv]
// One edge lane: dot products, endpoint decisions and the split interior compare.
module stq_edge (
  input  logic                   clk,
  input  stq_pkg::dvec_t         w_s,
  input  stq_pkg::dvec_t         w_e,
  input  stq_pkg::dvec_t         d,
  input  logic [stq_pkg::UW-1:0] r2,
  output logic                   hit_r
);

  localparam int UW = stq_pkg::UW;
  localparam int HW = stq_pkg::HW;
  localparam int SW = stq_pkg::SW;
  localparam int FW = stq_pkg::FW;
  localparam int PW = 2 * stq_pkg::DW;

  // Stage two: dot products.
  logic signed [PW-1:0] p_wd [3];
  logic signed [PW-1:0] p_ww [3];
  logic signed [PW-1:0] p_vv [3];
  logic signed [PW-1:0] p_dd [3];
  logic signed [SW-1:0] t_nxt, ww_s, vv_s, ll_s;
  logic signed [SW-1:0] t_r;
  logic [UW-1:0]        ww_r, vv_r, len2_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      p_wd[a] = w_s[a] * d[a];
      p_ww[a] = w_s[a] * w_s[a];
      p_vv[a] = w_e[a] * w_e[a];
      p_dd[a] = d[a] * d[a];
    end
    t_nxt = SW'(p_wd[0]) + SW'(p_wd[1]) + SW'(p_wd[2]);
    ww_s  = SW'(p_ww[0]) + SW'(p_ww[1]) + SW'(p_ww[2]);
    vv_s  = SW'(p_vv[0]) + SW'(p_vv[1]) + SW'(p_vv[2]);
    ll_s  = SW'(p_dd[0]) + SW'(p_dd[1]) + SW'(p_dd[2]);
  end

  always_ff @(posedge clk) begin
    t_r    <= t_nxt;
    ww_r   <= ww_s[UW-1:0];
    vv_r   <= vv_s[UW-1:0];
    len2_r <= ll_s[UW-1:0];
  end

  // Stage three: decide the endpoint cases and form half-width partial products.
  logic          t_pos, t_ge, ww_in;
  logic          early_nxt, need_nxt, early_r, need_r;
  logic [UW-1:0] a_val, tt_val;
  logic [UW-1:0] ab_hh_r, ab_hl_r, ab_lh_r, ab_ll_r, tt_hh_r, tt_hl_r, tt_ll_r;

  always_comb begin
    t_pos  = t_r > 0;
    t_ge   = t_r >= $signed({1'b0, len2_r});
    ww_in  = ww_r <= r2;
    a_val  = ww_r - r2;
    tt_val = t_r[UW-1:0];
    if (!t_pos) begin
      early_nxt = ww_in;
    end else if (t_ge) begin
      early_nxt = vv_r <= r2;
    end else begin
      early_nxt = 1'b1;
    end
    need_nxt = t_pos && !t_ge && !ww_in;
  end

  always_ff @(posedge clk) begin
    early_r <= early_nxt;
    need_r  <= need_nxt;
    ab_hh_r <= a_val[UW-1:HW] * len2_r[UW-1:HW];
    ab_hl_r <= a_val[UW-1:HW] * len2_r[HW-1:0];
    ab_lh_r <= a_val[HW-1:0]  * len2_r[UW-1:HW];
    ab_ll_r <= a_val[HW-1:0]  * len2_r[HW-1:0];
    tt_hh_r <= tt_val[UW-1:HW] * tt_val[UW-1:HW];
    tt_hl_r <= tt_val[UW-1:HW] * tt_val[HW-1:0];
    tt_ll_r <= tt_val[HW-1:0]  * tt_val[HW-1:0];
  end

  // Stage four: assemble the full products.
  logic [FW-1:0] ab_r, tt_r;
  logic          early2_r, need2_r;

  always_ff @(posedge clk) begin
    ab_r     <= (FW'(ab_hh_r) << (2 * HW)) + (FW'(ab_hl_r) << HW)
              + (FW'(ab_lh_r) << HW) + FW'(ab_ll_r);
    tt_r     <= (FW'(tt_hh_r) << (2 * HW)) + (FW'(tt_hl_r) << (HW + 1))
              + FW'(tt_ll_r);
    early2_r <= early_r;
    need2_r  <= need_r;
  end

  // Stage five: interior compare (w.w - r*r) * L <= t*t.
  always_ff @(posedge clk) begin
    hit_r <= need2_r ? (ab_r <= tt_r) : early2_r;
  end

endmodule
